>>> sv/afd_pkg.sv
package afd_pkg;

    localparam int MAX_CLASSES     = 128;
    localparam int INPUT_SIZE      = 640;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_W           = 28;

    localparam int SCALE_COUNT     = 3;
    localparam int FIRST_SCORE_COL = 5;
    localparam int STRIDE0_SHIFT   = 3;   // strides 8, 16, 32
    localparam int GRID0           = INPUT_SIZE / 8;
    localparam int GRID1           = INPUT_SIZE / 16;
    localparam int GRID2           = INPUT_SIZE / 32;

    localparam int COORD_MAX       = 4095;
    localparam int COORD_MIN       = -4096;

    // configuration register indexes
    localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CLASS_COUNT     = 2'd1;

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    typedef struct packed {
        logic [6:0]        cls;
        logic [15:0]       score;
        logic [15:0]       obj;
        logic [3:0][15:0]  regs;
        logic [6:0]        cell_x;
        logic [6:0]        cell_y;
        logic [1:0]        scale;
        logic              last;
    } row_t;

    typedef struct packed {
        logic [6:0]  cls;
        logic [15:0] conf;
        logic [12:0] left;
        logic [12:0] top;
        logic [11:0] width;
        logic [11:0] height;
        logic        last;
    } result_t;

    function automatic logic [7:0] grid_of(logic [1:0] scale);
        case (scale)
            2'd0:    grid_of = 8'(GRID0);
            2'd1:    grid_of = 8'(GRID1);
            default: grid_of = 8'(GRID2);
        endcase
    endfunction

    // signed quotient truncated toward zero by shift and subtract; den > 0
    function automatic longint div_toward_zero(longint num, longint den);
        logic [63:0] mag;
        logic [63:0] quo;
        logic [64:0] rem;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], mag[b]};
            if (rem >= 65'(den)) begin
                rem    = rem - 65'(den);
                quo[b] = 1'b1;
            end
        end
        div_toward_zero = (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // e^x in Q.16 for x = -8 + 16*k/EXP_TABLE_DEPTH: Taylor sum of e^(x/16)
    // in Q.24, then four squarings. Elaboration only.
    function automatic logic [EXP_W-1:0] exp_sample(int k);
        longint      y;
        longint      term;
        longint      sum;
        logic [63:0] s;
        y    = ((longint'(k) << 24) >> EXP_IDX_W) - (longint'(1) << 23);
        term = longint'(1) << 24;
        sum  = term;
        for (int i = 1; i <= 12; i++) begin
            term = div_toward_zero(term * y, longint'(i) << 24);
            sum  = sum + term;
        end
        s = 64'(sum);
        for (int i = 0; i < 4; i++) begin
            s = (s * s + (64'd1 << 23)) >> 24;
        end
        exp_sample = EXP_W'((s + 64'd128) >> 8);
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t rom;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            rom[k] = exp_sample(k);
        end
        build_exp_rom = rom;
    endfunction

    // clamp Q7.8 regression to [-8, 8) and pick the sample at or below it
    function automatic logic [EXP_IDX_W-1:0] exp_index(logic [15:0] raw);
        logic signed [15:0] r;
        logic [11:0]        u;
        logic [24:0]        prod;
        logic [12:0]        idx;
        r = signed'(raw);
        if (r < -16'sd2048) begin
            u = 12'd0;
        end else if (r > 16'sd2047) begin
            u = 12'hFFF;
        end else begin
            u = 12'(r + 16'sd2048);
        end
        prod = 25'(u) * 25'(EXP_TABLE_DEPTH);
        idx  = prod[24:12];
        if (idx >= 13'(EXP_TABLE_DEPTH)) begin
            idx = 13'(EXP_TABLE_DEPTH - 1);
        end
        exp_index = idx[EXP_IDX_W-1:0];
    endfunction

    // corner = trunc((2*centre_q8*256 - size_q16) / 2^17), saturated
    function automatic logic [12:0] corner(logic signed [23:0] centre, logic [32:0] size);
        logic signed [35:0] x17;
        logic signed [35:0] q;
        x17 = (36'(centre) <<< 9) - signed'(36'(size));
        if (x17 < 36'sd0) begin
            q = (x17 + 36'sd131071) >>> 17;
        end else begin
            q = x17 >>> 17;
        end
        if (q > 36'(COORD_MAX)) begin
            corner = 13'(COORD_MAX);
        end else if (q < 36'(COORD_MIN)) begin
            corner = 13'(COORD_MIN);
        end else begin
            corner = q[12:0];
        end
    endfunction

    function automatic logic [11:0] extent(logic [32:0] size);
        logic [16:0] v;
        v = size[32:16];
        extent = (v > 17'(COORD_MAX)) ? 12'(COORD_MAX) : v[11:0];
    endfunction

endpackage

>>> sv/anchor_free_detection_decode_top.sv
// Channel  Dir  Ports                            Content
// s_       in   s_tvalid s_tready s_tdata[15:0]  one head output word per beat
// m_       out  m_tvalid m_tready m_tdata[79:0]  one detection per beat
//                                  m_tlast        set on the frame's last cell
// cfg_     in   cfg_we cfg_index cfg_wdata       register writes, no read-back
//
// One word per cycle while s_tready is high; after the row's last word a
// detection passes the row register, multiply/ROM register and output register.
// Synchronous active-low reset clears counters and valid flags; config resets
// to threshold 39322, 80 classes.
// s_tready drops only while a detection is ready to leave the pipeline and
// the output register holds an untaken beat.
module anchor_free_detection_decode_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] word
    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] class_id, [22:7] confidence, [35:23] left, [48:36] top,
    // [60:49] box_width, [72:61] box_height, [79:73] zero
    output logic [79:0] m_tdata,
    output logic        m_tlast,   // frame_done
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import afd_pkg::*;

    logic [15:0] threshold_reg;
    logic [7:0]  class_count_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        en;
    logic        accept;
    row_t        row;
    logic        row_valid;
    result_t     res;
    logic        hit;

    assign en       = !(hit && out_valid_reg && !m_tready);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= 16'd39322;
            class_count_reg <= 8'd80;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCORE_THRESHOLD: threshold_reg   <= cfg_wdata;
                REG_CLASS_COUNT:     class_count_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    afd_row_tracker u_row (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .accept      (accept),
        .word        (s_tdata),
        .class_count (class_count_reg),
        .row         (row),
        .row_valid   (row_valid)
    );

    afd_box_decode u_box (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .row             (row),
        .row_valid       (row_valid),
        .score_threshold (threshold_reg),
        .res             (res),
        .hit             (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en && hit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && hit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.height, out_reg.width, out_reg.top, out_reg.left,
                       out_reg.conf, out_reg.cls};
    assign m_tlast  = out_reg.last;

endmodule

>>> sv/afd_row_tracker.sv
module afd_row_tracker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          accept,
    input  logic [15:0]   word,
    input  logic [7:0]    class_count,
    output afd_pkg::row_t row,
    output logic          row_valid
);
    import afd_pkg::*;

    logic [7:0]       column_reg;
    logic [6:0]       cell_x_reg;
    logic [6:0]       cell_y_reg;
    logic [1:0]       scale_reg;
    logic [3:0][15:0] regs_reg;
    logic [15:0]      obj_reg;
    logic [15:0]      best_reg;
    logic [6:0]       cls_reg;
    row_t             row_reg;
    logic             row_valid_reg;

    logic [7:0] cc;
    logic [7:0] k;
    logic       is_score;
    logic       take;
    logic       row_end;
    logic [7:0] grid;
    logic       x_wrap;
    logic       y_wrap;
    row_t       row_next;

    always_comb begin
        if (class_count == 8'd0) begin
            cc = 8'd1;
        end else if (class_count > 8'(MAX_CLASSES)) begin
            cc = 8'(MAX_CLASSES);
        end else begin
            cc = class_count;
        end
        k        = column_reg - 8'(FIRST_SCORE_COL);
        is_score = column_reg >= 8'(FIRST_SCORE_COL);
        take     = (k == 8'd0) || (word > best_reg);
        // a class index at or past the last class closes the row
        row_end  = accept && is_score && !((9'(k) + 9'd1) < 9'(cc));
        grid     = grid_of(scale_reg);
        x_wrap   = (8'(cell_x_reg) + 8'd1) >= grid;
        y_wrap   = (8'(cell_y_reg) + 8'd1) >= grid;

        row_next.cls    = take ? k[6:0] : cls_reg;
        row_next.score  = take ? word : best_reg;
        row_next.obj    = obj_reg;
        row_next.regs   = regs_reg;
        row_next.cell_x = cell_x_reg;
        row_next.cell_y = cell_y_reg;
        row_next.scale  = scale_reg;
        row_next.last   = (scale_reg == 2'(SCALE_COUNT - 1)) && x_wrap && y_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            cell_x_reg    <= '0;
            cell_y_reg    <= '0;
            scale_reg     <= '0;
            row_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                column_reg <= row_end ? 8'd0 : column_reg + 8'd1;
            end
            if (row_end) begin
                if (x_wrap) begin
                    cell_x_reg <= '0;
                    if (y_wrap) begin
                        cell_y_reg <= '0;
                        scale_reg  <= (scale_reg == 2'(SCALE_COUNT - 1)) ? 2'd0
                                                                          : scale_reg + 2'd1;
                    end else begin
                        cell_y_reg <= cell_y_reg + 7'd1;
                    end
                end else begin
                    cell_x_reg <= cell_x_reg + 7'd1;
                end
            end
            if (en) begin
                row_valid_reg <= row_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (column_reg < 8'd4) begin
                regs_reg[column_reg[1:0]] <= word;
            end else if (column_reg == 8'd4) begin
                obj_reg <= word;
            end else if (take) begin
                best_reg <= word;
                cls_reg  <= k[6:0];
            end
        end
        if (row_end) begin
            row_reg <= row_next;
        end
    end

    assign row       = row_reg;
    assign row_valid = row_valid_reg;

endmodule

>>> sv/afd_box_decode.sv
module afd_box_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  afd_pkg::row_t    row,
    input  logic             row_valid,
    input  logic [15:0]      score_threshold,
    output afd_pkg::result_t res,
    output logic             hit
);
    import afd_pkg::*;

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    logic                 valid_reg;
    logic [15:0]          conf_reg;
    logic [6:0]           cls_reg;
    logic                 last_reg;
    logic [1:0]           scale_reg;
    logic signed [23:0]   cx_reg;
    logic signed [23:0]   cy_reg;
    logic [EXP_W-1:0]     exp_w_reg;
    logic [EXP_W-1:0]     exp_h_reg;

    logic [31:0]          prod;
    logic [2:0]           shift;
    logic signed [16:0]   cx_base;
    logic signed [16:0]   cy_base;
    logic [EXP_IDX_W-1:0] idx_w;
    logic [EXP_IDX_W-1:0] idx_h;
    logic [2:0]           shift2;
    logic [32:0]          size_w;
    logic [32:0]          size_h;

    always_comb begin
        prod    = 32'(row.obj) * 32'(row.score);
        shift   = 3'(STRIDE0_SHIFT) + 3'(row.scale);
        cx_base = 17'(signed'(row.regs[0])) + signed'({2'b00, row.cell_x, 8'h00});
        cy_base = 17'(signed'(row.regs[1])) + signed'({2'b00, row.cell_y, 8'h00});
        idx_w   = exp_index(row.regs[2]);
        idx_h   = exp_index(row.regs[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= row_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && row_valid) begin
            conf_reg  <= prod[31:16];
            cls_reg   <= row.cls;
            last_reg  <= row.last;
            scale_reg <= row.scale;
            cx_reg    <= 24'(cx_base) <<< shift;
            cy_reg    <= 24'(cy_base) <<< shift;
            exp_w_reg <= EXP_ROM[idx_w];
            exp_h_reg <= EXP_ROM[idx_h];
        end
    end

    always_comb begin
        shift2     = 3'(STRIDE0_SHIFT) + 3'(scale_reg);
        size_w     = 33'(exp_w_reg) << shift2;
        size_h     = 33'(exp_h_reg) << shift2;
        res.cls    = cls_reg;
        res.conf   = conf_reg;
        res.left   = corner(cx_reg, size_w);
        res.top    = corner(cy_reg, size_h);
        res.width  = extent(size_w);
        res.height = extent(size_h);
        res.last   = last_reg;
        hit        = valid_reg && (conf_reg > score_threshold);
    end

endmodule

>>> sv/afd_checker.sv
module afd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);

    // an untaken beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // input stalls only behind output backpressure
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // confidence strictly above a threshold is never zero
    a_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:7] != 16'd0)
        else $error("detection with zero confidence");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind anchor_free_detection_decode_top afd_checker u_afd_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import afd_pkg::*;

    localparam int LAT_PAD     = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int FRAME_CELLS = GRID0 * GRID0 + GRID1 * GRID1 + GRID2 * GRID2;

    typedef struct {
        logic [6:0]  class_id;
        logic [15:0] confidence;
        logic [12:0] left;
        logic [12:0] top;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic        frame_done;
    } detection_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // decoder model state
    logic [27:0] exp_q16 [EXP_TABLE_DEPTH];
    logic [15:0] thr_q16 = 16'd39322;
    logic [7:0]  cls_cfg = 8'd80;
    logic [7:0]  col = '0;
    logic [6:0]  cx = '0;
    logic [6:0]  cy = '0;
    logic [1:0]  scale_sel = '0;
    logic [15:0] regs_q [4] = '{default: '0};
    logic [15:0] obj_q = '0;
    logic [15:0] best_q = '0;
    logic [6:0]  best_cls = '0;

    logic [15:0] head_words [$];
    detection_t  pending_dets [$];
    int          words_left = 0;
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          quiet_cycles = 0;

    anchor_free_detection_decode_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // e^x in Q.16, x = -8 + 16*k/depth: Taylor series of e^(x/16) in Q.24, squared 4x
    function automatic logic [27:0] exp_entry(int k);
        longint          y;
        longint          term;
        longint          acc;
        longint unsigned s;
        int              i;
        y    = ((longint'(k) << 24) / EXP_TABLE_DEPTH) - (longint'(1) << 23);
        term = longint'(1) << 24;
        acc  = term;
        for (i = 1; i <= 12; i++) begin
            term = (term * y) / (longint'(i) * (longint'(1) << 24));
            acc  = acc + term;
        end
        s = unsigned'(acc);
        for (i = 0; i < 4; i++) begin
            s = (s * s + (64'd1 << 23)) >> 24;
        end
        return 28'((s + 64'd128) >> 8);
    endfunction

    function automatic int eff_classes();
        if (cls_cfg == 8'd0) return 1;
        if (int'(cls_cfg) > MAX_CLASSES) return MAX_CLASSES;
        return int'(cls_cfg);
    endfunction

    function automatic longint size_q16(logic [15:0] raw, int stride);
        int r;
        int idx;
        r = int'(signed'(raw));
        if (r < -2048) r = -2048;
        if (r > 2047) r = 2047;
        idx = ((r + 2048) * EXP_TABLE_DEPTH) >> 12;
        if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
        return longint'(exp_q16[idx]) * stride;
    endfunction

    // 2*centre - size in Q.16, divided by 2^17 and truncated toward zero
    function automatic logic [12:0] box_edge(logic [15:0] raw, int pos, int stride, longint sz);
        longint centre;
        longint v;
        centre = (longint'(signed'(raw)) + longint'(pos) * 256) * stride;
        v = (centre * 512 - sz) / 131072;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return 13'(v);
    endfunction

    function automatic logic [11:0] box_extent(longint sz);
        longint v;
        v = sz >>> 16;
        return (v > COORD_MAX) ? 12'(COORD_MAX) : 12'(v);
    endfunction

    function automatic int cell_index();
        case (scale_sel)
            2'd0:    return int'(cy) * GRID0 + int'(cx);
            2'd1:    return GRID0 * GRID0 + int'(cy) * GRID1 + int'(cx);
            default: return GRID0 * GRID0 + GRID1 * GRID1 + int'(cy) * GRID2 + int'(cx);
        endcase
    endfunction

    task automatic decode_word(input logic [15:0] w);
        int          cc;
        int          k;
        int          stride;
        int          grid;
        logic [31:0] prod;
        longint      sw;
        longint      sh;
        detection_t  d;
        cc = eff_classes();
        if (col < 8'd4) begin
            regs_q[col[1:0]] = w;
            col++;
        end else if (col == 8'd4) begin
            obj_q = w;
            col++;
        end else begin
            k = int'(col) - FIRST_SCORE_COL;
            if (k == 0 || w > best_q) begin
                best_q   = w;
                best_cls = 7'(k);
            end
            // a lowered class count ends the row on the first score past it
            if (k + 1 < cc) begin
                col++;
            end else begin
                col    = '0;
                stride = 8 << scale_sel;
                grid   = INPUT_SIZE / stride;
                prod   = 32'(obj_q) * 32'(best_q);
                if (prod[31:16] > thr_q16) begin
                    sw = size_q16(regs_q[2], stride);
                    sh = size_q16(regs_q[3], stride);
                    d.class_id   = best_cls;
                    d.confidence = prod[31:16];
                    d.left       = box_edge(regs_q[0], int'(cx), stride, sw);
                    d.top        = box_edge(regs_q[1], int'(cy), stride, sh);
                    d.box_width  = box_extent(sw);
                    d.box_height = box_extent(sh);
                    d.frame_done = (int'(scale_sel) == SCALE_COUNT - 1) &&
                                   (int'(cx) + 1 >= grid) && (int'(cy) + 1 >= grid);
                    pending_dets.insert(pending_dets.size(), d);
                end
                if (int'(cx) + 1 >= grid) begin
                    cx = '0;
                    if (int'(cy) + 1 >= grid) begin
                        cy = '0;
                        scale_sel = (int'(scale_sel) + 1 >= SCALE_COUNT) ? 2'd0
                                                                         : scale_sel + 2'd1;
                    end else begin
                        cy++;
                    end
                end else begin
                    cx++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_detection();
        detection_t want;
        if (pending_dets.size() == 0) begin
            report_mismatch($sformatf("unexpected detection %h last %b", m_tdata, m_tlast));
        end else begin
            want = pending_dets.pop_front();
            cmp_field("class_id",   16'(m_tdata[6:0]),   16'(want.class_id));
            cmp_field("confidence", m_tdata[22:7],       want.confidence);
            cmp_field("left",       16'(m_tdata[35:23]), 16'(want.left));
            cmp_field("top",        16'(m_tdata[48:36]), 16'(want.top));
            cmp_field("box_width",  16'(m_tdata[60:49]), 16'(want.box_width));
            cmp_field("box_height", 16'(m_tdata[72:61]), 16'(want.box_height));
            cmp_field("pad",        16'(m_tdata[79:73]), 16'h0000);
            cmp_field("frame_done", 16'(m_tlast),        16'(want.frame_done));
        end
    endtask

    // driver: bursts of beats with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_word(s_tdata);
                words_left--;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || head_words.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= head_words.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 100)
                                                                  : $urandom_range(24, 1);
                        gap_left   = $urandom_range(6, 0);
                    end
                end
            end
        end
    end

    // monitor: check each detection beat, stall on segments of random mode
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_detection();
            if (rx_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: rx_mode = RX_OPEN;
                    4, 5, 6:    rx_mode = RX_COIN;
                    7, 8:       rx_mode = RX_SPARSE;
                    default:    rx_mode = RX_HOLD;
                endcase
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(16, 2) : $urandom_range(64, 4);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_word(input logic [15:0] w);
        head_words.insert(head_words.size(), w);
        words_left++;
    endtask

    function automatic logic [15:0] rand_reg();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2:       return $urandom_range(0, 1) ? 16'hF800 : 16'h07FF;
            3:       return 16'($urandom_range(128, 0) - 64);
            default: return 16'($urandom_range(4095, 0) - 2048);
        endcase
    endfunction

    // hit: aim objectness and best score to clear the threshold (not with zero_scores)
    task automatic push_row(input int n_cls, input bit hit, input bit zero_scores);
        logic [15:0] obj;
        logic [15:0] best;
        logic [15:0] s;
        longint      need;
        int          best_at;
        int          i;
        repeat (4) push_word(rand_reg());
        if (hit && thr_q16 != 16'hFFFF) begin
            obj  = 16'($urandom_range(65535, int'(thr_q16) + 1));
            need = ((longint'(thr_q16) + 1) * 65536 + longint'(obj) - 1) / longint'(obj);
            best = (need > 65535) ? 16'hFFFF : 16'($urandom_range(65535, int'(need)));
        end else begin
            obj  = 16'($urandom);
            best = 16'($urandom);
        end
        push_word(obj);
        best_at = $urandom_range(n_cls - 1, 0);
        for (i = 0; i < n_cls; i++) begin
            if (zero_scores) s = 16'h0000;
            else if (i == best_at || $urandom_range(0, 7) == 0) s = best;
            else s = 16'($urandom_range(int'(best), 0));
            push_word(s);
        end
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SCORE_THRESHOLD) thr_q16 = value;
        else if (idx == REG_CLASS_COUNT) cls_cfg = value[7:0];
    endtask

    task automatic set_mode(input logic [15:0] thr, input logic [7:0] classes);
        write_cfg(REG_SCORE_THRESHOLD, thr);
        write_cfg(REG_CLASS_COUNT, {8'($urandom), classes});
    endtask

    // all beats taken, all detections seen, pipeline flushed
    task automatic drain();
        while (words_left != 0 || pending_dets.size() != 0) @(posedge aclk);
        repeat (LAT_PAD) @(posedge aclk);
    endtask

    initial begin
        int          p;
        int          budget;
        int          rows;
        int          n;
        int          start;
        logic [15:0] thr;
        logic [7:0]  classes;

        for (p = 0; p < EXP_TABLE_DEPTH; p++) exp_q16[p] = exp_entry(p);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme boxes, tied full scores
        set_mode(16'h0000, 8'd2);
        push_word(16'h8000); push_word(16'h7FFF); push_word(16'h8000); push_word(16'h7FFF);
        push_word(16'hFFFF); push_word(16'hFFFF); push_word(16'hFFFF);
        drain();

        // zero class count acts as one; confidence equal to threshold is dropped
        set_mode(16'd16384, 8'd0);
        push_word(16'h0100); push_word(16'h0080); push_word(16'h0000); push_word(16'h0000);
        push_word(16'h8000); push_word(16'h8000);
        push_word(16'hFF00); push_word(16'h0000); push_word(16'h07FF); push_word(16'hF800);
        push_word(16'h8002); push_word(16'h8000);
        drain();

        // class count lowered in the middle of a row
        write_cfg(REG_CLASS_COUNT, {8'hA5, 8'd8});
        push_word(16'h0000); push_word(16'h0000); push_word(16'h0000); push_word(16'h0000);
        push_word(16'hFFFF); push_word(16'h0100); push_word(16'hC000);
        drain();
        write_cfg(REG_CLASS_COUNT, {8'h5A, 8'd1});
        push_word(16'hFFFF);
        drain();

        for (p = 0; p < 9; p++) begin
            case ($urandom_range(0, 3))
                0:       thr = 16'($urandom);
                1:       thr = 16'($urandom_range(4000, 0));
                2:       thr = 16'($urandom_range(50000, 30000));
                default: thr = 16'($urandom_range(65535, 60000));
            endcase
            classes = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(40, 9))
                                                  : 8'($urandom_range(8, 1));
            case (p)
                0: begin thr = 16'hFFFF; classes = 8'd5;   end
                1: begin thr = 16'h0000; classes = 8'd128; end
                2: classes = 8'd255;
                default: ;
            endcase
            set_mode(thr, classes);
            budget = 110;
            while (budget > 0) begin
                push_row(eff_classes(), $urandom_range(0, 1), $urandom_range(0, 9) == 0);
                budget -= eff_classes() + FIRST_SCORE_COL;
            end
            drain();
        end

        // a run of one-class rows, hits forced near scale and frame boundaries
        set_mode(16'($urandom_range(60000, 20000)), 8'd1);
        start = cell_index();
        rows  = 40;
        for (p = 0; p < rows; p++) begin
            n = (start + p) % FRAME_CELLS;
            push_row(1, n == GRID0 * GRID0 - 1 || n == GRID0 * GRID0 ||
                        n == FRAME_CELLS - GRID2 * GRID2 - 1 ||
                        n == FRAME_CELLS - GRID2 * GRID2 ||
                        n == FRAME_CELLS - 1 || n == 0 || $urandom_range(0, 19) == 0, 1'b0);
        end
        drain();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/afd_pkg.sv
sv/afd_row_tracker.sv
sv/afd_box_decode.sv
sv/anchor_free_detection_decode_top.sv
sv/afd_checker.sv
dv/tb_top.sv
